// File: hw/rtl/pslm_pkg.sv
// ----------------------------------------------------------------------------
// pslm_pkg
// Shared types and constants of the packet sequence and latency monitor.
// ----------------------------------------------------------------------------
package pslm_pkg;

  localparam int SEQ_BITS = 32;
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [31:0] GAP_LIMIT_RESET = 32'd1000000;

  typedef enum logic {
    OP_PACKET = 1'b0,
    OP_WINDOW = 1'b1
  } op_e;

  typedef logic [SEQ_BITS-1:0] seq_t;

  // classified item handed from front to back
  typedef struct packed {
    op_e         op;
    logic        gap_vld;
    seq_t        gap;
    logic        lat_ok;
    logic [63:0] lat;
  } entry_t;

endpackage

// File: hw/rtl/pslm_if.sv
// ----------------------------------------------------------------------------
// pslm_if
// Channel interfaces: receive items, result items and configuration writes.
// ----------------------------------------------------------------------------
interface pslm_item_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] seq_number;
  logic [63:0] tx_time;
  logic [63:0] rx_time;

  modport source (output valid, operation, seq_number, tx_time, rx_time, input ready);
  modport sink (input valid, operation, seq_number, tx_time, rx_time, output ready);
endinterface

interface pslm_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] total_received;
  logic [63:0] window_received;
  logic [63:0] missed_count;
  logic [31:0] this_gap;
  logic        latency_taken;
  logic [63:0] latency_min;
  logic [63:0] latency_max;
  logic [63:0] latency_sum;
  logic [63:0] latency_samples;

  modport source (
    output valid, total_received, window_received, missed_count, this_gap,
           latency_taken, latency_min, latency_max, latency_sum, latency_samples,
    input  ready
  );
  modport sink (
    input  valid, total_received, window_received, missed_count, this_gap,
           latency_taken, latency_min, latency_max, latency_sum, latency_samples,
    output ready
  );
endinterface

interface pslm_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/pslm_front.sv
// ----------------------------------------------------------------------------
// pslm_front
// Accepts receive items, tracks the sequence, computes gap and latency.
// ----------------------------------------------------------------------------
module pslm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  pslm_item_if.sink         item_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output pslm_pkg::entry_t  entry_o
);

  logic            seen_q, seen_d;
  pslm_pkg::seq_t  prev_q, prev_d;
  pslm_pkg::seq_t  seq, expected;
  logic [64:0]     lat_diff;
  logic            is_pkt, accept;

  assign item_i.ready = push_ready_i;
  assign push_valid_o = item_i.valid;
  assign accept       = item_i.valid && push_ready_i;
  assign is_pkt       = (pslm_pkg::op_e'(item_i.operation) == pslm_pkg::OP_PACKET);

  assign seq      = pslm_pkg::SEQ_BITS'(item_i.seq_number);
  assign expected = prev_q + pslm_pkg::SEQ_BITS'(1);
  assign lat_diff = {1'b0, item_i.rx_time} - {1'b0, item_i.tx_time};

  always_comb begin
    entry_o.op      = pslm_pkg::op_e'(item_i.operation);
    entry_o.gap_vld = is_pkt && seen_q;
    entry_o.gap     = seq - expected;
    entry_o.lat_ok  = is_pkt && (item_i.tx_time != 64'd0) && !lat_diff[64];
    entry_o.lat     = lat_diff[63:0];
  end

  always_comb begin
    seen_d = seen_q;
    prev_d = prev_q;
    if (accept && is_pkt) begin
      seen_d = 1'b1;
      prev_d = seq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      prev_q <= '0;
    end else begin
      seen_q <= seen_d;
      prev_q <= prev_d;
    end
  end

endmodule

// File: hw/rtl/pslm_fifo.sv
// ----------------------------------------------------------------------------
// pslm_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module pslm_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  pslm_pkg::entry_t  push_entry_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output pslm_pkg::entry_t  pop_entry_o
);

  pslm_pkg::entry_t                 mem_q [pslm_pkg::FIFO_DEPTH];
  logic [pslm_pkg::PTR_W-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [pslm_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic                             push, pop;

  function automatic logic [pslm_pkg::PTR_W-1:0] nxt(input logic [pslm_pkg::PTR_W-1:0] p);
    nxt = (p == pslm_pkg::PTR_W'(pslm_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready_o = (cnt_q != pslm_pkg::CNT_W'(pslm_pkg::FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? nxt(wr_q) : wr_q;
    rd_d  = pop ? nxt(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

endmodule

// File: hw/rtl/pslm_back.sv
// ----------------------------------------------------------------------------
// pslm_back
// Updates counters and latency statistics, holds the result register.
// ----------------------------------------------------------------------------
module pslm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  pslm_cfg_if.sink          cfg_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  pslm_pkg::entry_t  entry_i,
  pslm_result_if.source     result_o
);

  logic [31:0] limit_q, limit_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] total_q, total_d, win_q, win_d, missed_q, missed_d;
  logic [63:0] min_q, min_d, max_q, max_d, sum_q, sum_d, samples_q, samples_d;
  logic [31:0] gap_q, gap_d;
  logic        taken_q, taken_d;
  logic        pop, gap_ok, is_pkt;
  logic [64:0] sum_ext;

  assign cfg_i.ready = 1'b1;
  assign limit_d     = (cfg_i.valid) ? cfg_i.data : limit_q;

  assign pop_ready_o = !out_valid_q || result_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;
  assign is_pkt      = (entry_i.op == pslm_pkg::OP_PACKET);
  assign gap_ok      = entry_i.gap_vld && (entry_i.gap != '0)
                       && (64'(entry_i.gap) < 64'(limit_q));
  assign sum_ext     = {1'b0, sum_q} + {1'b0, entry_i.lat};

  always_comb begin
    out_valid_d = out_valid_q;
    total_d     = total_q;
    win_d       = win_q;
    missed_d    = missed_q;
    min_d       = min_q;
    max_d       = max_q;
    sum_d       = sum_q;
    samples_d   = samples_q;
    gap_d       = gap_q;
    taken_d     = taken_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (pop) begin
      out_valid_d = 1'b1;
      gap_d       = '0;
      taken_d     = 1'b0;
      if (!is_pkt) begin
        win_d = '0;
      end else begin
        total_d = total_q + 64'd1;
        win_d   = win_q + 64'd1;
        if (gap_ok) begin
          missed_d = missed_q + 64'(entry_i.gap);
          gap_d    = 32'(entry_i.gap);
        end
        if (entry_i.lat_ok) begin
          taken_d   = 1'b1;
          samples_d = samples_q + 64'd1;
          sum_d     = sum_ext[64] ? '1 : sum_ext[63:0];
          if (entry_i.lat < min_q) begin
            min_d = entry_i.lat;
          end
          if (entry_i.lat > max_q) begin
            max_d = entry_i.lat;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= pslm_pkg::GAP_LIMIT_RESET;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      win_q       <= '0;
      missed_q    <= '0;
      min_q       <= '1;
      max_q       <= '0;
      sum_q       <= '0;
      samples_q   <= '0;
      gap_q       <= '0;
      taken_q     <= 1'b0;
    end else begin
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
      win_q       <= win_d;
      missed_q    <= missed_d;
      min_q       <= min_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
      samples_q   <= samples_d;
      gap_q       <= gap_d;
      taken_q     <= taken_d;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.total_received  = total_q;
  assign result_o.window_received = win_q;
  assign result_o.missed_count    = missed_q;
  assign result_o.this_gap        = gap_q;
  assign result_o.latency_taken   = taken_q;
  assign result_o.latency_min     = min_q;
  assign result_o.latency_max     = max_q;
  assign result_o.latency_sum     = sum_q;
  assign result_o.latency_samples = samples_q;

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (samples_q != 64'd0) |-> (min_q <= max_q))
    else $error("latency min above max");

  a_taken_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken_q |-> (samples_q != 64'd0))
    else $error("latency taken without a sample");

  a_window_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !is_pkt) |=> (win_q == 64'd0))
    else $error("window count not cleared");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && is_pkt) |=> (total_q == $past(total_q) + 64'd1))
    else $error("total count did not advance");

endmodule

// File: hw/rtl/packet_sequence_latency_monitor_unit.sv
// ----------------------------------------------------------------------------
// packet_sequence_latency_monitor_unit
// Per-stream receive monitor: packet counts, sequence gaps, latency stats.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   transfer
//  item_i    in   operation, seq_number, tx_time, rx_time   valid & ready
//  result_o  out  counters, gap, latency statistics         valid & ready
//  cfg_i     in   gap_limit write data                      valid & ready
//
//  One item per cycle sustained while result_o is ready; a transferred item
//  passes front classify, the 2-entry queue and back update into the result register.
//  cfg_i is always ready; write only while no item is in flight.
//  Reset clears all counters, min latency to all ones, gap_limit to 1000000.
//  A stalled result_o backs up the queue; item_i drops ready when it fills.
// ----------------------------------------------------------------------------
module packet_sequence_latency_monitor_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  pslm_item_if.sink      item_i,
  pslm_cfg_if.sink       cfg_i,
  pslm_result_if.source  result_o
);

  logic             push_valid, push_ready, pop_valid, pop_ready;
  pslm_pkg::entry_t push_entry, pop_entry;

  pslm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .entry_o      (push_entry)
  );

  pslm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  pslm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .entry_i     (pop_entry),
    .result_o    (result_o)
  );

endmodule
